FILE: rtl/btot_pkg.sv
// ----------------------------------------------------------------------------
// btot_pkg
// shared constants for the box / triangle overlap pipeline
// ----------------------------------------------------------------------------
package btot_pkg;

    // default coordinate width, q8.8
    localparam int COORD_BITS_DEF = 16;

    // three vertices, three dimensions
    localparam int N_VERT = 3;
    localparam int N_DIM  = 3;

    // cyclic successor and predecessor of a dimension or vertex index
    localparam int NEXT_IDX [3] = '{1, 2, 0};
    localparam int PREV_IDX [3] = '{2, 0, 1};

endpackage

FILE: rtl/btot_axis_check.sv
// ----------------------------------------------------------------------------
// btot_axis_check
// interval of three projections against a symmetric radius on one axis
// ----------------------------------------------------------------------------
module btot_axis_check #(
    parameter int W = 8
) (
    input  logic signed [W-1:0] proj [btot_pkg::N_VERT],
    input  logic        [W-1:0] radius,
    output logic                overlap
);
    import btot_pkg::*;

    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;
    logic signed [W-1:0] r_pos;
    logic signed [W-1:0] r_neg;

    // radius is always below half the range, so it reads as a positive value
    always_comb begin
        lo = proj[0];
        hi = proj[0];
        for (int j = 1; j < N_VERT; j++) begin
            if (proj[j] < lo) lo = proj[j];
            if (proj[j] > hi) hi = proj[j];
        end
        r_pos   = $signed(radius);
        r_neg   = -r_pos;
        // touching counts as overlap
        overlap = !((lo > r_pos) || (hi < r_neg));
    end

endmodule

FILE: rtl/box_triangle_overlap_test_core.sv
// ----------------------------------------------------------------------------
// box_triangle_overlap_test_core
// exact 13-axis separating axis test between an aligned box and a triangle
// ----------------------------------------------------------------------------
// One box / triangle pair per beat goes in and one overlap flag per beat comes
// out, in order. The pipeline has six register stages, and a new pair can be
// taken in every cycle while s_tready is high. The depth of the pipeline is
// set by the longest chain of dependent multiplies: edge products form the
// triangle normal, and only then can the vertices be projected onto it and
// the radius be scaled by it. Each stage has its own valid bit and is loaded
// whenever it is empty or its successor moves, so a stalled output fills the
// pipeline up before s_tready drops. All arithmetic is exact two's complement
// on the coordinate codes; a projection interval that just reaches the box
// radius counts as overlapping, and a degenerate triangle never separates on
// its zero axes.
// ----------------------------------------------------------------------------
module box_triangle_overlap_test_core #(
    parameter int COORD_BITS = btot_pkg::COORD_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // vertex_a, vertex_b, vertex_c, box_center, box_half_size from bit 0 up,
    // each 3*COORD_BITS wide, zero padded to whole bytes
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((15*COORD_BITS+7)/8)*8-1:0]        s_tdata,

    // overlaps in bit 0, zero padded
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [7:0]                                m_tdata
);
    import btot_pkg::*;

    // ------------------------------------------------------------------------
    // widths
    // ------------------------------------------------------------------------
    localparam int CW   = COORD_BITS;      // one coordinate code
    localparam int FW   = N_DIM * CW;      // one packed field
    localparam int VW   = CW + 1;          // box-relative vertex, edge
    localparam int BW   = VW + 1;          // box axis compare
    localparam int EPW  = 2 * VW;          // edge x vertex product
    localparam int ERW  = CW + VW;         // half size x edge magnitude
    localparam int EXW  = EPW + 1;         // normal component, edge axis compare
    localparam int MW   = VW + EXW;        // vertex x normal product
    localparam int HW   = CW + EXW;        // half size x normal magnitude
    localparam int NPW  = CW + EXW + 3;    // normal axis compare
    localparam int NSTG = 6;

    // ------------------------------------------------------------------------
    // stage control: a stage loads when empty or when its successor moves
    // ------------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] vld_in;
    logic [NSTG:0]   rdy;

    assign rdy[NSTG] = m_tready;

    genvar gs;
    generate
        for (gs = 0; gs < NSTG; gs++) begin : g_rdy
            assign rdy[gs] = !vld_reg[gs] || rdy[gs+1];
        end
    endgenerate

    assign vld_in   = {vld_reg[NSTG-2:0], s_tvalid};
    assign vld_next = (rdy[NSTG-1:0] & vld_in) | (~rdy[NSTG-1:0] & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTG-1];

    // ------------------------------------------------------------------------
    // stage 1: unpack, move to box-centred coordinates, form edges
    // ------------------------------------------------------------------------
    logic signed [CW-1:0] crd  [N_VERT][N_DIM];
    logic signed [CW-1:0] ctr  [N_DIM];
    logic        [CW-1:0] half [N_DIM];

    logic signed [VW-1:0] v1_next [N_VERT][N_DIM];
    logic signed [VW-1:0] e1_next [N_VERT][N_DIM];
    logic signed [VW-1:0] v1_reg  [N_VERT][N_DIM];
    logic signed [VW-1:0] e1_reg  [N_VERT][N_DIM];
    logic        [CW-1:0] h1_reg  [N_DIM];

    always_comb begin
        for (int k = 0; k < N_DIM; k++) begin
            ctr[k]  = s_tdata[N_VERT*FW + k*CW +: CW];
            half[k] = s_tdata[(N_VERT+1)*FW + k*CW +: CW];
            for (int j = 0; j < N_VERT; j++) begin
                crd[j][k] = s_tdata[j*FW + k*CW +: CW];
            end
        end
        for (int k = 0; k < N_DIM; k++) begin
            for (int j = 0; j < N_VERT; j++) begin
                v1_next[j][k] = VW'(crd[j][k]) - VW'(ctr[k]);
                // the centre cancels, so edges come straight from the vertices
                e1_next[j][k] = VW'(crd[NEXT_IDX[j]][k]) - VW'(crd[j][k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            v1_reg <= v1_next;
            e1_reg <= e1_next;
            h1_reg <= half;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: box axes, normal partial products, edge axis products
    // ------------------------------------------------------------------------
    logic signed [BW-1:0]  bx_proj [N_DIM][N_VERT];
    logic        [BW-1:0]  bx_rad  [N_DIM];
    logic [N_DIM-1:0]      box_hit;
    logic        [VW-1:0]  emag    [N_VERT][N_DIM];

    logic signed [EPW-1:0] np2_next [N_DIM][2];
    logic signed [EPW-1:0] pa2_next [N_DIM][N_VERT][N_VERT];
    logic signed [EPW-1:0] pb2_next [N_DIM][N_VERT][N_VERT];
    logic        [ERW-1:0] ra2_next [N_DIM][N_VERT];
    logic        [ERW-1:0] rb2_next [N_DIM][N_VERT];

    logic signed [EPW-1:0] np2_reg  [N_DIM][2];
    logic signed [EPW-1:0] pa2_reg  [N_DIM][N_VERT][N_VERT];
    logic signed [EPW-1:0] pb2_reg  [N_DIM][N_VERT][N_VERT];
    logic        [ERW-1:0] ra2_reg  [N_DIM][N_VERT];
    logic        [ERW-1:0] rb2_reg  [N_DIM][N_VERT];
    logic signed [VW-1:0]  v2_reg   [N_VERT][N_DIM];
    logic        [CW-1:0]  h2_reg   [N_DIM];
    logic                  box_ok2_reg;

    genvar gk, gi;
    generate
        for (gk = 0; gk < N_DIM; gk++) begin : g_box
            btot_axis_check #(
                .W (BW)
            ) u_box_axis (
                .proj    (bx_proj[gk]),
                .radius  (bx_rad[gk]),
                .overlap (box_hit[gk])
            );
        end
    endgenerate

    // axis k x edge i projects vertex j to v[b]*e[a] - v[a]*e[b],
    // with a, b the two other dimensions in cyclic order
    always_comb begin
        for (int k = 0; k < N_DIM; k++) begin
            bx_rad[k] = BW'(h1_reg[k]);
            for (int j = 0; j < N_VERT; j++) begin
                bx_proj[k][j] = BW'(v1_reg[j][k]);
            end
        end
        for (int i = 0; i < N_VERT; i++) begin
            for (int d = 0; d < N_DIM; d++) begin
                emag[i][d] = e1_reg[i][d][VW-1] ? VW'(-e1_reg[i][d]) : VW'(e1_reg[i][d]);
            end
        end
        for (int k = 0; k < N_DIM; k++) begin
            np2_next[k][0] = EPW'(e1_reg[0][NEXT_IDX[k]]) * EPW'(e1_reg[1][PREV_IDX[k]]);
            np2_next[k][1] = EPW'(e1_reg[0][PREV_IDX[k]]) * EPW'(e1_reg[1][NEXT_IDX[k]]);
            for (int i = 0; i < N_VERT; i++) begin
                ra2_next[k][i] = ERW'(h1_reg[NEXT_IDX[k]]) * ERW'(emag[i][PREV_IDX[k]]);
                rb2_next[k][i] = ERW'(h1_reg[PREV_IDX[k]]) * ERW'(emag[i][NEXT_IDX[k]]);
                for (int j = 0; j < N_VERT; j++) begin
                    pa2_next[k][i][j] = EPW'(v1_reg[j][PREV_IDX[k]])
                                      * EPW'(e1_reg[i][NEXT_IDX[k]]);
                    pb2_next[k][i][j] = EPW'(v1_reg[j][NEXT_IDX[k]])
                                      * EPW'(e1_reg[i][PREV_IDX[k]]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            np2_reg     <= np2_next;
            pa2_reg     <= pa2_next;
            pb2_reg     <= pb2_next;
            ra2_reg     <= ra2_next;
            rb2_reg     <= rb2_next;
            v2_reg      <= v1_reg;
            h2_reg      <= h1_reg;
            box_ok2_reg <= &box_hit;
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: normal components, edge axis projections and radii
    // ------------------------------------------------------------------------
    logic signed [EXW-1:0] n3_next  [N_DIM];
    logic signed [EXW-1:0] ep3_next [N_DIM][N_VERT][N_VERT];
    logic        [EXW-1:0] er3_next [N_DIM][N_VERT];

    logic signed [EXW-1:0] n3_reg   [N_DIM];
    logic signed [EXW-1:0] ep3_reg  [N_DIM][N_VERT][N_VERT];
    logic        [EXW-1:0] er3_reg  [N_DIM][N_VERT];
    logic signed [VW-1:0]  v3_reg   [N_VERT][N_DIM];
    logic        [CW-1:0]  h3_reg   [N_DIM];
    logic                  box_ok3_reg;

    always_comb begin
        for (int k = 0; k < N_DIM; k++) begin
            n3_next[k] = EXW'(np2_reg[k][0]) - EXW'(np2_reg[k][1]);
            for (int i = 0; i < N_VERT; i++) begin
                er3_next[k][i] = EXW'(ra2_reg[k][i]) + EXW'(rb2_reg[k][i]);
                for (int j = 0; j < N_VERT; j++) begin
                    ep3_next[k][i][j] = EXW'(pa2_reg[k][i][j]) - EXW'(pb2_reg[k][i][j]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            n3_reg      <= n3_next;
            ep3_reg     <= ep3_next;
            er3_reg     <= er3_next;
            v3_reg      <= v2_reg;
            h3_reg      <= h2_reg;
            box_ok3_reg <= box_ok2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: an edge axis check per axis and edge, normal projection products
    // ------------------------------------------------------------------------
    logic [N_DIM-1:0][N_VERT-1:0] edge_hit;
    logic        [EXW-1:0] nmag     [N_DIM];
    logic signed [MW-1:0]  nm4_next [N_VERT][N_DIM];
    logic        [HW-1:0]  nr4_next [N_DIM];

    logic signed [MW-1:0]  nm4_reg  [N_VERT][N_DIM];
    logic        [HW-1:0]  nr4_reg  [N_DIM];
    logic                  ok4_reg;

    generate
        for (gk = 0; gk < N_DIM; gk++) begin : g_edge_k
            for (gi = 0; gi < N_VERT; gi++) begin : g_edge_i
                btot_axis_check #(
                    .W (EXW)
                ) u_edge_axis (
                    .proj    (ep3_reg[gk][gi]),
                    .radius  (er3_reg[gk][gi]),
                    .overlap (edge_hit[gk][gi])
                );
            end
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < N_DIM; k++) begin
            nmag[k]     = n3_reg[k][EXW-1] ? EXW'(-n3_reg[k]) : EXW'(n3_reg[k]);
            nr4_next[k] = HW'(h3_reg[k]) * HW'(nmag[k]);
            for (int j = 0; j < N_VERT; j++) begin
                nm4_next[j][k] = MW'(v3_reg[j][k]) * MW'(n3_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            nm4_reg <= nm4_next;
            nr4_reg <= nr4_next;
            ok4_reg <= box_ok3_reg & (&edge_hit);
        end
    end

    // ------------------------------------------------------------------------
    // stage 5: normal axis projections and radius
    // ------------------------------------------------------------------------
    logic signed [NPW-1:0] np5_next [N_VERT];
    logic        [NPW-1:0] nr5_next;

    logic signed [NPW-1:0] np5_reg  [N_VERT];
    logic        [NPW-1:0] nr5_reg;
    logic                  ok5_reg;

    always_comb begin
        for (int j = 0; j < N_VERT; j++) begin
            np5_next[j] = NPW'(nm4_reg[j][0]) + NPW'(nm4_reg[j][1]) + NPW'(nm4_reg[j][2]);
        end
        nr5_next = NPW'(nr4_reg[0]) + NPW'(nr4_reg[1]) + NPW'(nr4_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            np5_reg <= np5_next;
            nr5_reg <= nr5_next;
            ok5_reg <= ok4_reg;
        end
    end

    // ------------------------------------------------------------------------
    // stage 6: normal axis check, output register
    // ------------------------------------------------------------------------
    logic norm_hit;
    logic ovl_next;
    logic ovl_reg;

    btot_axis_check #(
        .W (NPW)
    ) u_norm_axis (
        .proj    (np5_reg),
        .radius  (nr5_reg),
        .overlap (norm_hit)
    );

    assign ovl_next = ok5_reg & norm_hit;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            ovl_reg <= ovl_next;
        end
    end

    assign m_tdata = {7'd0, ovl_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // input side only stalls once every stage holds a beat
    a_stall_full : assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg)
    ) else $error("input stalled with a bubble in the pipeline");

    // a free output never blocks the input
    a_ready_through : assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready
    ) else $error("input stalled while output is ready");

    // a box or edge separation forces a zero result
    a_sep_kills : assert property (
        @(posedge aclk) disable iff (!aresetn)
        (vld_reg[4] && rdy[5] && !ok5_reg) |=> !ovl_reg
    ) else $error("separated pair reported as overlapping");

endmodule
